FILE: hdl/rollw_pkg.sv
// Shared constants and types for the rolling Adler-32 window block.
package rollw_pkg;

    localparam logic [16:0] ADLER_MOD   = 17'd65521;
    localparam int          WLEN_W      = 11;
    localparam logic [10:0] WLEN_RESET  = 11'd700;

    // Word index of the window length register (paddr[2])
    localparam logic        REG_WINDOW_LEN = 1'b0;

    typedef struct packed {
        logic [15:0] high;
        logic [15:0] low;
    } t_sums;

endpackage

FILE: hdl/rollw_ring.sv
// Byte ring of the checksum window: one write port, one registered read port.
module rollw_ring #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // write-first: a read of the address written this cycle sees the new byte
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/rollw_update.sv
// Modular Adler-32 sum update: plain step while filling, rolling step when full.
module rollw_update
    import rollw_pkg::*;
(
    input  logic        i_roll,
    input  logic [7:0]  i_byte_in,
    input  logic [7:0]  i_byte_out,
    input  logic [16:0] i_n_mod,
    input  t_sums       i_sums,
    output t_sums       o_sums
);

    logic [24:0] prod;
    logic [16:0] wred;
    logic [15:0] weight;
    logic [16:0] a_add;
    logic [15:0] a_fill;
    logic [16:0] a_sub;
    logic [15:0] a_roll;
    logic [15:0] a_new;
    logic [16:0] b_sum;
    logic [15:0] b_red;
    logic [17:0] v;
    logic [15:0] b_new;

    always_comb begin
        // n*out mod M, using 2^16 = 15 (mod M)
        prod   = {8'd0, i_n_mod} * {17'd0, i_byte_out};
        wred   = {8'd0, prod[24:16]} * 17'd15 + {1'b0, prod[15:0]};
        weight = (wred >= ADLER_MOD) ? 16'(wred - ADLER_MOD) : wred[15:0];

        a_add  = {1'b0, i_sums.low} + {9'd0, i_byte_in};
        a_fill = (a_add >= ADLER_MOD) ? 16'(a_add - ADLER_MOD) : a_add[15:0];

        // (a + in) + M - out lies in [M-255, 2M-1]
        a_sub  = {1'b0, a_fill} + ADLER_MOD - {9'd0, i_byte_out};
        a_roll = (a_sub >= ADLER_MOD) ? 16'(a_sub - ADLER_MOD) : a_sub[15:0];

        a_new = i_roll ? a_roll : a_fill;

        b_sum = {1'b0, i_sums.high} + {1'b0, a_new};
        b_red = (b_sum >= ADLER_MOD) ? 16'(b_sum - ADLER_MOD) : b_sum[15:0];

        // b - weight - 1 lies in [-M, M-2]
        v = {2'b00, b_red} - {2'b00, weight} - 18'd1;
        if (v[17]) begin
            v = v + {1'b0, ADLER_MOD};
        end

        b_new = i_roll ? v[15:0] : b_red;

        o_sums.low  = a_new;
        o_sums.high = b_new;
    end

endmodule

FILE: hdl/rolling_adler32_window.sv
// Rolling Adler-32 checksum over a sliding byte window, top level.
//
// Slave stream: one byte per request (tdata), tuser = restart flag, which
// clears the sums and the window fill before its byte is taken.
// Master stream: one result per byte; tdata = checksum (sum_high in the
// upper 16 bits, sum_low in the lower), tuser = window-full flag.
// APB port: register 0 (address 0) holds the window length, 11 bits. A zero
// length acts as 1, a length above MAX_WINDOW as MAX_WINDOW. Writing it also
// restarts the window. Write only while the stream is idle.
// Path: an accepted request passes through the input register, then the
// result register. Throughput: one byte per cycle while the master side
// takes results; the byte leaving the window is prefetched from the ring
// ahead of its use, so the single ring read port keeps up with that rate.
// While the master side stalls, one more request is held in the input
// register, then tready drops until the result is taken.
// Reset: sums 1 and 0, empty window, length 700; ring contents need no
// clearing since every entry is written before it is read.
module rolling_adler32_window
    import rollw_pkg::*;
#(
    parameter int MAX_WINDOW = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  i_s_axis_tuser,   // [0] restart
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] checksum
    output logic [0:0]  o_m_axis_tuser,   // [0] window_full
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NW = $clog2(MAX_WINDOW + 1);
    localparam int AW = $clog2(MAX_WINDOW);

    function automatic logic [NW-1:0] eff_len(input logic [WLEN_W-1:0] w);
        int unsigned t;
        t = 32'(w);
        if (t == 0) begin
            t = 1;
        end
        if (t > MAX_WINDOW) begin
            t = MAX_WINDOW;
        end
        return t[NW-1:0];
    endfunction

    function automatic logic [16:0] len_mod(input logic [NW-1:0] n);
        logic [16:0] n17;
        n17 = 17'(n);
        return (n17 >= ADLER_MOD) ? 17'(n17 - ADLER_MOD) : n17;
    endfunction

    logic [WLEN_W-1:0] r_window_len;
    logic [NW-1:0]     r_n;
    logic [16:0]       r_n_mod;
    t_sums             r_sums;
    logic [AW-1:0]     r_oldest;
    logic [NW-1:0]     r_fill;

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_restart;

    logic              r_out_valid;
    logic [31:0]       r_out_sum;
    logic              r_out_full;

    logic              cfg_wr;
    logic              accept;
    logic              process;
    t_sums             cur_sums;
    t_sums             n_sums;
    logic [NW-1:0]     cur_fill;
    logic [AW-1:0]     cur_oldest;
    logic              roll;
    logic [NW-1:0]     oldest_inc;
    logic [AW-1:0]     n_oldest;
    logic [NW-1:0]     n_fill;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [7:0]        byte_out;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_WINDOW_LEN) ? 32'(r_window_len) : 32'd0;

    assign process         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || process;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        if (r_in_restart) begin
            cur_sums.high = 16'd0;
            cur_sums.low  = 16'd1;
            cur_fill      = '0;
            cur_oldest    = '0;
        end else begin
            cur_sums   = r_sums;
            cur_fill   = r_fill;
            cur_oldest = r_oldest;
        end

        roll       = (cur_fill == r_n);
        oldest_inc = NW'(cur_oldest) + NW'(1);
        if (roll) begin
            n_oldest = (oldest_inc == r_n) ? '0 : oldest_inc[AW-1:0];
            n_fill   = cur_fill;
            wr_addr  = cur_oldest;
        end else begin
            n_oldest = cur_oldest;
            n_fill   = cur_fill + NW'(1);
            wr_addr  = cur_fill[AW-1:0];
        end

        // prefetch the byte that leaves with the next request
        rd_addr = process ? n_oldest : r_oldest;
    end

    rollw_ring #(
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (process),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_in_byte),
        .i_rd_addr (rd_addr),
        .o_rd_data (byte_out)
    );

    rollw_update u_update (
        .i_roll     (roll),
        .i_byte_in  (r_in_byte),
        .i_byte_out (byte_out),
        .i_n_mod    (r_n_mod),
        .i_sums     (cur_sums),
        .o_sums     (n_sums)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WLEN_RESET;
            r_n          <= eff_len(WLEN_RESET);
            r_n_mod      <= len_mod(eff_len(WLEN_RESET));
            r_sums.high  <= 16'd0;
            r_sums.low   <= 16'd1;
            r_oldest     <= '0;
            r_fill       <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WINDOW_LEN) begin
                r_window_len <= pwdata[WLEN_W-1:0];
                r_n          <= eff_len(pwdata[WLEN_W-1:0]);
                r_n_mod      <= len_mod(eff_len(pwdata[WLEN_W-1:0]));
                r_sums.high  <= 16'd0;
                r_sums.low   <= 16'd1;
                r_oldest     <= '0;
                r_fill       <= '0;
            end
        end else if (process) begin
            r_sums   <= n_sums;
            r_oldest <= n_oldest;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte    <= i_s_axis_tdata;
            r_in_restart <= i_s_axis_tuser[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out_sum  <= {n_sums.high, n_sums.low};
            r_out_full <= (n_fill == r_n);
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_sum;
    assign o_m_axis_tuser[0] = r_out_full;

    // fill never passes the window length
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_n)
        else $error("fill count above window length");

    // ring pointer stays inside the window
    a_oldest_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        NW'(r_oldest) < r_n)
        else $error("oldest index outside window");

    // pointer only moves once the window is full
    a_oldest_filling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != r_n) |-> (r_oldest == '0))
        else $error("oldest index moved while filling");

    // a processed request always lands in the result register
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process |=> r_out_valid)
        else $error("processed request produced no result");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the rolling Adler-32 window block.
`timescale 1ns / 1ps

module testbench
    import rollw_pkg::*;
;

    localparam int unsigned MOD       = ADLER_MOD;
    localparam int unsigned RING_SIZE = 1024;
    localparam int          LONG_HOLD = 300;

    typedef struct packed {
        logic [31:0] checksum;
        logic        full;
    } t_adler_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        src_valid;
    logic        src_ready;
    logic [7:0]  src_byte;
    logic [0:0]  src_restart;
    logic        res_valid;
    logic        sink_ready;
    logic [31:0] res_checksum;
    logic [0:0]  res_full;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [10:0] win_len;
    logic [7:0]  ring_mem [RING_SIZE];
    logic [15:0] sum_lo;
    logic [15:0] sum_hi;
    int unsigned oldest_idx;
    int unsigned fill_cnt;

    t_adler_result expected_sums_q[$];
    int  mismatch_count;
    bit  src_idle_en;
    bit  sink_idle_en;
    bit  sink_hold_req;

    rolling_adler32_window i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (src_valid),
        .o_s_axis_tready (src_ready),
        .i_s_axis_tdata  (src_byte),
        .i_s_axis_tuser  (src_restart),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (sink_ready),
        .o_m_axis_tdata  (res_checksum),
        .o_m_axis_tuser  (res_full),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void clear_sums();
        sum_lo     = 16'd1;
        sum_hi     = 16'd0;
        oldest_idx = 0;
        fill_cnt   = 0;
    endfunction

    // Computes the checksum after one byte and queues it.
    function automatic void roll_adler_predict(input logic [7:0] b, input logic rs);
        int unsigned n;
        int unsigned pos;
        int unsigned out_b;
        int unsigned weight;
        int unsigned lo;
        int unsigned hi;
        t_adler_result r;
        n = win_len;
        if (n == 0) n = 1;
        if (n > RING_SIZE) n = RING_SIZE;
        if (rs) clear_sums();
        if (fill_cnt < n) begin
            ring_mem[fill_cnt] = b;
            lo = (sum_lo + b) % MOD;
            hi = (sum_hi + lo) % MOD;
            fill_cnt++;
        end else begin
            pos = oldest_idx % n;
            out_b = ring_mem[pos];
            weight = (n * out_b) % MOD;
            ring_mem[pos] = b;
            oldest_idx = (pos + 1) % n;
            lo = (sum_lo + MOD - out_b + b) % MOD;
            hi = (sum_hi + MOD - weight + lo + MOD - 1) % MOD;
        end
        sum_lo = lo[15:0];
        sum_hi = hi[15:0];
        r.checksum = {sum_hi, sum_lo};
        r.full = (fill_cnt == n);
        expected_sums_q.insert(expected_sums_q.size(), r);
    endfunction

    function automatic logic [7:0] rand_byte();
        int unsigned k;
        k = $urandom_range(0, 7);
        if (k == 0) return 8'h00;
        if (k == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic rs);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            @(negedge i_clk);
            src_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        src_valid   <= 1'b1;
        src_byte    <= b;
        src_restart <= rs;
        do @(posedge i_clk); while (!src_ready);
        roll_adler_predict(b, rs);
    endtask

    // Drops valid and waits until every checksum is back and the pipe is empty.
    task automatic settle();
        @(negedge i_clk);
        src_valid <= 1'b0;
        while (expected_sums_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr[2] == REG_WINDOW_LEN) begin
            win_len = data[10:0];
            clear_sums();
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_window(input logic [31:0] len);
        settle();
        apb_write(3'd0, len);
    endtask

    task automatic test_reset_default();
        // window of 700 out of reset; restart on the very first byte
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);   // restart while filling
        send_byte(8'hFE, 1'b0);
    endtask

    task automatic test_length_extremes();
        set_window(32'd1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b1);
        set_window(32'd0);        // zero acts as one
        send_byte(8'hAA, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        set_window(32'hA5A5_0002); // only the low 11 bits count
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);   // restart while full
        send_byte(8'h3C, 1'b0);
        settle();
        apb_write(3'd4, 32'd9);   // no such register: no effect, no restart
        send_byte(8'hC3, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
    endtask

    task automatic test_max_window();
        set_window(32'd1024);
        repeat (100) send_byte(($urandom_range(0, 9) == 0) ? rand_byte() : 8'hFF, 1'b0);
        set_window(32'd2047);     // saturates to the ring size
        repeat (60) send_byte(rand_byte(), 1'b0);
    endtask

    task automatic test_backpressure();
        set_window(32'd16);
        src_idle_en = 1'b0;
        sink_hold_req = 1'b1;
        repeat (60) send_byte(rand_byte(), 1'b0);
        src_idle_en = 1'b1;
    endtask

    task automatic test_random();
        int unsigned pick;
        int unsigned len;
        for (int ph = 0; ph < 10; ph++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) len = 0;
            else if (pick == 1) len = 1;
            else if (pick == 2) len = 700;
            else len = $urandom_range(2, 40);
            set_window(len);
            repeat ($urandom_range(20, 40))
                send_byte(rand_byte(), $urandom_range(0, 29) == 0);
        end
    endtask

    task automatic test_steady();
        set_window(32'd5);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (100) send_byte(rand_byte(), $urandom_range(0, 39) == 0);
    endtask

    // result sink: random stalls, plus one long hold on request
    initial begin
        int stall_left;
        stall_left = 0;
        sink_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_req) begin
                stall_left = LONG_HOLD;
                sink_hold_req = 1'b0;
            end else if (stall_left == 0 && sink_idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 14);
            end
            if (stall_left > 0) begin
                sink_ready <= 1'b0;
                stall_left--;
            end else begin
                sink_ready <= 1'b1;
            end
        end
    end

    initial begin
        t_adler_result exp_r;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_valid && sink_ready) begin
                if (expected_sums_q.size() == 0) begin
                    $error("unexpected result: checksum %h window_full %b",
                           res_checksum, res_full);
                    mismatch_count++;
                end else begin
                    exp_r = expected_sums_q.pop_front();
                    if (res_checksum !== exp_r.checksum) begin
                        $error("checksum: expected %h, actual %h", exp_r.checksum, res_checksum);
                        mismatch_count++;
                    end
                    if (res_full[0] !== exp_r.full) begin
                        $error("window_full: expected %b, actual %b", exp_r.full, res_full[0]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        src_valid     = 1'b0;
        src_byte      = 8'h00;
        src_restart   = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 3'd0;
        pwdata        = 32'd0;
        mismatch_count = 0;
        src_idle_en   = 1'b1;
        sink_idle_en  = 1'b1;
        sink_hold_req = 1'b0;
        win_len       = WLEN_RESET;
        clear_sums();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_default();
        test_length_extremes();
        test_backpressure();
        test_random();
        test_max_window();
        test_steady();

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_sums_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
